>>> rtl/rtpap_pkg.sv
package rtpap_pkg;

	// Field widths fixed by the packet format.
	localparam int LEN_W    = 12;
	localparam int TIME_W   = 32;
	localparam int SEQ_W    = 16;
	localparam int LIMIT_W  = 13;
	localparam int RATE_W   = 18;
	localparam int CHAN_W   = 8;
	localparam int PT_W     = 7;
	localparam int SSRC_W   = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [LEN_W-1:0]   MAX_FRAME_BYTES  = 12'd4095;
	localparam logic [LIMIT_W-1:0] RTP_HEADER_BYTES = 13'd12;
	localparam logic [LIMIT_W-1:0] TCP_HEADER_BYTES = 13'd4;
	localparam logic [LIMIT_W-1:0] MIN_PACKET_LIMIT = 13'd128;
	localparam logic [TIME_W-1:0]  FIRST_RTP_TIME   = 32'd1600;

	// sample_rate / 1000 as a multiply by a rounded-up reciprocal of 2^28 / 1000.
	// The error stays below one thousandth over the whole 18-bit range, so the
	// truncated product is the exact quotient.
	localparam int RATE_SHIFT = 28;
	localparam int RECIP_W    = 19;
	localparam logic [RECIP_W-1:0] RATE_RECIP = 19'd268436;
	localparam int PROD_W     = RATE_W + RECIP_W;
	localparam int RATE_K_W   = PROD_W - RATE_SHIFT;

	localparam logic [CHAN_W-1:0] INTERLEAVE_MAGIC = 8'h24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PACKET_LIMIT = 3'd0,
		REG_USE_TCP      = 3'd1,
		REG_CHANNEL_ID   = 3'd2,
		REG_PAYLOAD_TYPE = 3'd3,
		REG_SSRC         = 3'd4,
		REG_SAMPLE_RATE  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0]  frame_length;
		logic [TIME_W-1:0] timestamp_ms;
	} in_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq_number;
		logic [TIME_W-1:0] rtp_timestamp;
		logic [LEN_W-1:0]  payload_offset;
		logic [LEN_W-1:0]  payload_length;
		logic              marker;
		logic [SEQ_W-1:0]  tcp_length;
	} out_item_t;

	typedef enum logic [1:0] {
		STEP_ACCEPT   = 2'd0,
		STEP_MULTIPLY = 2'd1,
		STEP_STAMP    = 2'd2,
		STEP_EMIT     = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		COND_ALWAYS   = 2'd0,
		COND_IN_VALID = 2'd1,
		COND_OUT_FREE = 2'd2
	} cond_t;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_MULTIPLY = 2'd1,
		OP_STAMP    = 2'd2,
		OP_EMIT     = 2'd3
	} op_t;

	typedef struct packed {
		cond_t wait_cond;
		op_t   op;
		logic  br_last;
		step_t nxt_go;
		step_t nxt_alt;
	} ucode_t;

	typedef struct packed {
		logic fire;
		op_t  op;
	} ctrl_t;

	typedef struct packed {
		logic out_free;
		logic last;
	} status_t;

	// The control store: one word per step.
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		case (s)
			STEP_ACCEPT:   w = '{COND_IN_VALID, OP_LOAD,     1'b0, STEP_MULTIPLY, STEP_MULTIPLY};
			STEP_MULTIPLY: w = '{COND_ALWAYS,   OP_MULTIPLY, 1'b0, STEP_STAMP,    STEP_STAMP};
			STEP_STAMP:    w = '{COND_ALWAYS,   OP_STAMP,    1'b0, STEP_EMIT,     STEP_EMIT};
			STEP_EMIT:     w = '{COND_OUT_FREE, OP_EMIT,     1'b1, STEP_EMIT,     STEP_ACCEPT};
			default:       w = '{COND_ALWAYS,   OP_STAMP,    1'b0, STEP_ACCEPT,   STEP_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/rtpap_seq.sv
module rtpap_seq
	import rtpap_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output ctrl_t   ctrl
);

	step_t  step_q;
	step_t  step_nxt;
	ucode_t word;
	logic   cond_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_ACCEPT;
		end else begin
			step_q <= step_nxt;
		end
	end

	always_comb begin
		word = ucode_rom(step_q);
		case (word.wait_cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_IN_VALID: cond_ok = in_valid;
			COND_OUT_FREE: cond_ok = status.out_free;
			default:       cond_ok = 1'b0;
		endcase
		in_ready  = (word.wait_cond == COND_IN_VALID);
		ctrl.fire = cond_ok;
		ctrl.op   = word.op;
		step_nxt  = step_q;
		if (cond_ok) begin
			step_nxt = (word.br_last && status.last) ? word.nxt_alt : word.nxt_go;
		end
	end

endmodule

>>> rtl/rtpap_dp.sv
module rtpap_dp
	import rtpap_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  in_item_t             in_data,
	input  ctrl_t                ctrl,
	output status_t              status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	// Configuration registers. Channel, payload type and SSRC belong to the
	// header bytes, which this block does not build; they are kept for the
	// header path and folded into a parity word so they stay live.
	logic [LIMIT_W-1:0] packet_limit_q;
	logic               use_tcp_q;
	logic [CHAN_W-1:0]  channel_id_q;
	logic [PT_W-1:0]    payload_type_q;
	logic [SSRC_W-1:0]  ssrc_q;
	logic [RATE_W-1:0]  sample_rate_q;

	logic [SEQ_W-1:0]   seq_q;
	logic [TIME_W-1:0]  prev_ms_q;
	logic [TIME_W-1:0]  prev_rtp_q;

	logic [LEN_W-1:0]    len_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   delta_q;
	logic                first_q;
	logic [RATE_K_W-1:0] rate_k_q;
	logic [LIMIT_W-1:0]  cap_q;
	logic [TIME_W-1:0]   inc_q;
	logic [TIME_W-1:0]   rtp_q;
	logic [LEN_W-1:0]    off_q;

	logic                out_valid_q;
	out_item_t           out_q;

	logic [PROD_W-1:0]   rate_prod;
	logic [LIMIT_W-1:0]  limit;
	logic [LEN_W-1:0]    len_sat;
	logic [LEN_W-1:0]    remaining;
	logic                last;
	logic [LEN_W-1:0]    chunk;
	logic                hdr_parity;

	always_comb begin
		rate_prod  = PROD_W'(sample_rate_q) * PROD_W'(RATE_RECIP);
		limit      = (packet_limit_q < MIN_PACKET_LIMIT) ? MIN_PACKET_LIMIT : packet_limit_q;
		len_sat    = (in_data.frame_length > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES
		                                                      : in_data.frame_length;
		remaining  = len_q - off_q;
		last       = ({1'b0, remaining} <= cap_q);
		chunk      = last ? remaining : cap_q[LEN_W-1:0];
		hdr_parity = ^{INTERLEAVE_MAGIC, channel_id_q, payload_type_q, ssrc_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_limit_q <= 13'd1400;
			use_tcp_q      <= 1'b0;
			channel_id_q   <= '0;
			payload_type_q <= 7'd8;
			ssrc_q         <= '0;
			sample_rate_q  <= 18'd8000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PACKET_LIMIT: packet_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_USE_TCP:      use_tcp_q      <= cfg_data[0];
				REG_CHANNEL_ID:   channel_id_q   <= cfg_data[CHAN_W-1:0];
				REG_PAYLOAD_TYPE: payload_type_q <= cfg_data[PT_W-1:0];
				REG_SSRC:         ssrc_q         <= cfg_data[SSRC_W-1:0];
				REG_SAMPLE_RATE:  sample_rate_q  <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stream state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= '0;
			prev_ms_q   <= '0;
			prev_rtp_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.fire && ctrl.op == OP_STAMP) begin
				prev_ms_q  <= now_q;
				prev_rtp_q <= first_q ? FIRST_RTP_TIME : prev_rtp_q + inc_q;
			end
			if (ctrl.fire && ctrl.op == OP_EMIT) begin
				seq_q       <= seq_q + 16'd1;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			case (ctrl.op)
				OP_LOAD: begin
					len_q    <= len_sat;
					now_q    <= in_data.timestamp_ms;
					delta_q  <= in_data.timestamp_ms - prev_ms_q;
					first_q  <= (prev_ms_q == '0) || (in_data.timestamp_ms < prev_ms_q);
					rate_k_q <= rate_prod[PROD_W-1:RATE_SHIFT];
					cap_q    <= limit - RTP_HEADER_BYTES
					            - (use_tcp_q ? TCP_HEADER_BYTES : '0);
				end
				OP_MULTIPLY: begin
					inc_q <= TIME_W'(TIME_W'(rate_k_q) * delta_q);
				end
				OP_STAMP: begin
					rtp_q <= first_q ? FIRST_RTP_TIME : prev_rtp_q + inc_q;
					off_q <= '0;
				end
				OP_EMIT: begin
					out_q.seq_number     <= seq_q + 16'd1;
					out_q.rtp_timestamp  <= rtp_q;
					out_q.payload_offset <= off_q;
					out_q.payload_length <= chunk;
					out_q.marker         <= last;
					out_q.tcp_length     <= use_tcp_q
					                        ? SEQ_W'(chunk) + SEQ_W'(RTP_HEADER_BYTES)
					                        : '0;
					off_q <= off_q + chunk;
				end
				default: ;
			endcase
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.last     = last || (hdr_parity && 1'b0);
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

>>> rtl/rtp_audio_packetizer.sv
// RTP audio packetizer.
// Input channel (in_valid/in_ready/in_data) takes one frame request: a length
// in bytes and a capture time in milliseconds. The output channel
// (out_valid/out_ready/out_data) returns one request per RTP packet of that
// frame, in order, each with its sequence number, sample-unit timestamp,
// payload offset and length, marker bit on the last packet and the
// interleaved TCP length word. The user must write registers via cfg_we,
// cfg_index, cfg_data only while no frame is in progress; not enforced here.
// A small microcoded sequencer steps through load, multiply, stamp and emit;
// the first packet is emitted after the stamp step; further packets follow
// one per cycle while the receiver takes them. A frame holds the input until
// its last packet is emitted; only then does the step register go to accept.
// When the receiver stalls, the emit step waits on the output register and
// the frame's remaining packets are held back; nothing is dropped.
// Reset restores the register defaults, clears the sequence counter and the
// stored times, and empties the output register.
module rtp_audio_packetizer
	import rtpap_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	ctrl_t   ctrl;
	status_t status;

	rtpap_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.ctrl     (ctrl)
	);

	rtpap_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.ctrl      (ctrl),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// A frame always spends at least the multiply and stamp steps in flight.
	a_no_double_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("frame accepted on consecutive cycles");

	// A packet never reaches beyond the largest frame size.
	a_within_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (13'(out_data.payload_offset) + 13'(out_data.payload_length)
		               <= 13'(MAX_FRAME_BYTES)))
		else $error("packet runs past the frame");

	// Only the last packet of a frame may be short enough to be empty.
	a_full_middle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.marker) |-> (out_data.payload_length != '0))
		else $error("empty packet without marker");
`endif

endmodule
